// ----- rtl/core/icad_pkg.sv -----
// Shared types and constants of the interleaved channel average decimator.
package icad_pkg;

  // Widths of the configuration registers and of the channel field.
  localparam int unsigned CH_BITS   = 3;
  localparam int unsigned LEN_BITS  = 7;
  localparam int unsigned CFG_BITS  = 7;
  localparam int unsigned CFG_IDX_BITS = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CHANNEL_COUNT  = 2'd0,
    REG_AVERAGE_LENGTH = 2'd1
  } cfg_reg_e;

  // Control from the sequencer to the shared divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Status from the shared divider back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- rtl/core/icad_sample_if.sv -----
// Input channel carrying one signed converter sample per request.
interface icad_sample_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- rtl/core/icad_result_if.sv -----
// Output channel carrying one averaged channel value per request.
interface icad_result_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [icad_pkg::CH_BITS-1:0]  channel;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          last;

  modport source (output valid, output channel, output average, output last, input ready);
  modport sink   (input valid, input channel, input average, input last, output ready);
endinterface

// ----- rtl/core/icad_divider.sv -----
// Shared restoring divider: signed sum over unsigned length, one quotient bit per cycle.
module icad_divider #(
  parameter int unsigned NUM_W = 23,
  parameter int unsigned DEN_W = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  icad_pkg::div_ctrl_t      ctrl_i,
  input  logic signed [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]         den_i,
  output icad_pkg::div_status_t    status_o,
  output logic signed [NUM_W-1:0]  quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] work_q, work_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  // The remainder stays below the divisor, so the shifted value is below twice it.
  always_comb begin
    shifted = {rem_q, work_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = ~diff[DEN_W];
  end

  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      rem_d  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      work_d = {work_q[NUM_W-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (ctrl_i.start) begin
      cnt_q  <= CNT_W'(NUM_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      work_q <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      rem_q  <= '0;
      den_q  <= den_i;
      neg_q  <= num_i[NUM_W-1];
    end else begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign quot_o          = neg_q ? -$signed(work_q) : $signed(work_q);
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule

// ----- rtl/core/interleaved_channel_average_decimator.sv -----
// Top level: per-channel boxcar accumulation with decimated averaged output.
//
// Samples arrive on in_i interleaved by channel (ch0, ch1, ..., ch0, ...) and each
// is added to its channel's running sum. A sample that does not close a group is
// taken while ready stays high, so such samples may follow back to back.
// The sample that completes average_length frames starts the output phase: for each
// channel in order the shared restoring divider produces sum / length, truncated
// toward zero, through a setup state (S_START), the divider loop (S_DIV), a
// hand-over into the result register and the delivery on out_o (S_OUT). Results
// leave on out_o with channel index, average and a last flag on the highest
// channel. While the receiver holds ready low the result register keeps its value
// and the block waits; no sample is taken until the whole group has been delivered.
// A write on the configuration port (index 0 channel_count, 1 average_length)
// takes effect at once and restarts the group; other indexes are ignored.
// Reset sets both registers to 1 and clears sums, channel position and frame count.
module interleaved_channel_average_decimator #(
  parameter int unsigned MAX_CHANNELS = 6,
  parameter int unsigned MAX_AVERAGE  = 64,
  parameter int unsigned SAMPLE_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  icad_sample_if.sink                        in_i,
  icad_result_if.source                      out_o,
  input  logic                               cfg_we_i,
  input  logic [icad_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [icad_pkg::CFG_BITS-1:0]      cfg_data_i
);

  localparam int unsigned SUM_BITS = SAMPLE_BITS + $clog2(MAX_AVERAGE) + 1;
  localparam int unsigned IDX_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned FRM_W    = (MAX_AVERAGE > 1) ? $clog2(MAX_AVERAGE) : 1;
  localparam int unsigned CHB      = icad_pkg::CH_BITS;
  localparam int unsigned LENB     = icad_pkg::LEN_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_DIV   = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CHB-1:0]             ch_cfg_q;
  logic [LENB-1:0]            len_cfg_q;
  logic signed [SUM_BITS-1:0] sums_q [MAX_CHANNELS];
  logic [IDX_W-1:0]           pos_q;
  logic [FRM_W-1:0]           frame_q;
  logic [IDX_W-1:0]           j_q;

  logic [CHB-1:0]             out_ch_q;
  logic signed [SAMPLE_BITS-1:0] out_avg_q;
  logic                       out_last_q;

  logic [CHB-1:0]             eff_ch;
  logic [LENB-1:0]            eff_len;
  logic [IDX_W-1:0]           rd_idx;
  logic signed [SUM_BITS-1:0] rd_sum;
  logic signed [SUM_BITS-1:0] new_sum;
  logic                       in_take;
  logic                       out_take;
  logic                       pos_end;
  logic                       frame_end;
  logic                       j_last;
  logic                       cfg_hit;

  icad_pkg::div_ctrl_t        div_ctrl;
  icad_pkg::div_status_t      div_status;
  logic signed [SUM_BITS-1:0] div_quot;

  // Out-of-range register values fold to the nearest usable setting.
  always_comb begin
    if (ch_cfg_q == '0) begin
      eff_ch = CHB'(1);
    end else if (int'(ch_cfg_q) > int'(MAX_CHANNELS)) begin
      eff_ch = CHB'(MAX_CHANNELS);
    end else begin
      eff_ch = ch_cfg_q;
    end
    if (len_cfg_q == '0) begin
      eff_len = LENB'(1);
    end else if (int'(len_cfg_q) > int'(MAX_AVERAGE)) begin
      eff_len = LENB'(MAX_AVERAGE);
    end else begin
      eff_len = len_cfg_q;
    end
  end

  assign in_take   = in_i.valid && in_i.ready;
  assign out_take  = out_o.valid && out_o.ready;
  assign pos_end   = (int'(pos_q) + 1) >= int'(eff_ch);
  assign frame_end = (int'(frame_q) + 1) >= int'(eff_len);
  assign j_last    = (int'(j_q) + 1) >= int'(eff_ch);
  assign cfg_hit   = cfg_we_i && ((cfg_idx_i == icad_pkg::REG_CHANNEL_COUNT) ||
                                  (cfg_idx_i == icad_pkg::REG_AVERAGE_LENGTH));

  assign rd_idx  = (state_q == S_IDLE) ? pos_q : j_q;
  assign rd_sum  = sums_q[rd_idx];
  assign new_sum = rd_sum + {{(SUM_BITS-SAMPLE_BITS){in_i.sample[SAMPLE_BITS-1]}},
                             in_i.sample};

  assign div_ctrl.start = (state_q == S_START);

  icad_divider #(
    .NUM_W (SUM_BITS),
    .DEN_W (LENB)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (div_ctrl),
    .num_i    (rd_sum),
    .den_i    (eff_len),
    .status_o (div_status),
    .quot_o   (div_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_take && pos_end && frame_end) state_d = S_START;
      end
      S_START: state_d = S_DIV;
      S_DIV: begin
        if (div_status.done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_take) state_d = j_last ? S_IDLE : S_START;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ch_cfg_q  <= CHB'(1);
      len_cfg_q <= LENB'(1);
      pos_q     <= '0;
      frame_q   <= '0;
      j_q       <= '0;
      for (int i = 0; i < int'(MAX_CHANNELS); i++) sums_q[i] <= '0;
    end else if (cfg_hit) begin
      if (cfg_idx_i == icad_pkg::REG_CHANNEL_COUNT) begin
        ch_cfg_q <= cfg_data_i[CHB-1:0];
      end else begin
        len_cfg_q <= cfg_data_i[LENB-1:0];
      end
      state_q <= S_IDLE;
      pos_q   <= '0;
      frame_q <= '0;
      j_q     <= '0;
      for (int i = 0; i < int'(MAX_CHANNELS); i++) sums_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (in_take) begin
        sums_q[pos_q] <= new_sum;
        if (!pos_end) begin
          pos_q <= pos_q + IDX_W'(1);
        end else begin
          pos_q <= '0;
          if (!frame_end) begin
            frame_q <= frame_q + FRM_W'(1);
          end else begin
            frame_q <= '0;
            j_q     <= '0;
          end
        end
      end
      if (out_take) begin
        if (j_last) begin
          // The whole group has gone out, so the sums restart from zero.
          j_q <= '0;
          for (int i = 0; i < int'(MAX_CHANNELS); i++) sums_q[i] <= '0;
        end else begin
          j_q <= j_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV && div_status.done) begin
      out_ch_q   <= CHB'(j_q);
      out_avg_q  <= div_quot[SAMPLE_BITS-1:0];
      out_last_q <= j_last;
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = (state_q == S_OUT);
  assign out_o.channel = out_ch_q;
  assign out_o.average = out_avg_q;
  assign out_o.last    = out_last_q;

  // No sample may be taken while a result is still on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a result is pending");

  // The last flag marks exactly the highest configured channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last == (int'(out_o.channel) + 1 == int'(eff_ch))))
    else $error("last flag does not match channel position");

  // The divider is idle whenever a result is being offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !div_status.busy)
    else $error("divider busy during result hand-over");

  // Delivering the last result of a group returns the block to taking samples.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && out_o.last && !cfg_hit) |=> in_i.ready)
    else $error("block did not return to accepting samples after group end");

endmodule
